// ===== design/h264nf_pkg.sv =====
// ----------------------------------------------------------------------------
// h264nf_pkg
// Shared types, constants and helpers of the H.264 NAL fragmenter.
// ----------------------------------------------------------------------------
package h264nf_pkg;

  localparam int SIZE_BITS_DEF = 24;   // width of the packet position counters
  localparam int PKT_SIZE_W    = 24;   // width of the packet_size field
  localparam int LIMIT_W       = 16;   // width of max_packet_bytes
  localparam int START_LEN     = 4;    // start code bytes
  localparam int MIN_PACKET    = 5;    // shorter packets are dropped
  localparam int NAL_POS       = 5;    // position of the NAL header byte
  localparam int MAX_RESULTS   = 3;    // results one input byte can cause
  localparam int OUTQ_DEPTH    = 4;    // result slots in the output queue
  localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1402;
  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 16'd3;

  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] NRI_MASK  = 8'h60;
  localparam logic [7:0] TYPE_MASK = 8'h1F;
  localparam logic [7:0] START_BIT = 8'h80;
  localparam logic [7:0] END_BIT   = 8'h40;

  typedef struct packed {
    logic [7:0]            in_byte;
    logic                  first_of_packet;
    logic [PKT_SIZE_W-1:0] packet_size;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       packet_begin;
    logic       packet_finish;
    logic       run_last;
  } result_t;

  // Results of one input byte, lowest slot first.
  typedef struct packed {
    logic [1:0]                  cnt;
    result_t [MAX_RESULTS-1:0]   res;
  } bundle_t;

  function automatic result_t mk_res(logic [7:0] b, logic bg, logic fn, logic ls);
    result_t r;
    r.out_byte      = b;
    r.packet_begin  = bg;
    r.packet_finish = fn;
    r.run_last      = ls;
    return r;
  endfunction

endpackage

// ===== design/h264nf_in_if.sv =====
// ----------------------------------------------------------------------------
// h264nf_in_if
// Input byte channel: valid/ready handshake with one video packet byte.
// ----------------------------------------------------------------------------
interface h264nf_in_if import h264nf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [7:0]            in_byte;
  logic                  first_of_packet;
  logic [PKT_SIZE_W-1:0] packet_size;

  modport source (output valid, output in_byte, output first_of_packet,
                  output packet_size, input ready);
  modport sink   (input valid, input in_byte, input first_of_packet,
                  input packet_size, output ready);
endinterface

// ===== design/h264nf_out_if.sv =====
// ----------------------------------------------------------------------------
// h264nf_out_if
// Result byte channel: valid/ready handshake with one output packet byte.
// ----------------------------------------------------------------------------
interface h264nf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_begin;
  logic       packet_finish;
  logic       run_last;

  modport source (output valid, output out_byte, output packet_begin,
                  output packet_finish, output run_last, input ready);
  modport sink   (input valid, input out_byte, input packet_begin,
                  input packet_finish, input run_last, output ready);
endinterface

// ===== design/h264nf_step.sv =====
// ----------------------------------------------------------------------------
// h264nf_step
// Packet tracking state and the per-byte step that yields up to three results.
// ----------------------------------------------------------------------------
module h264nf_step import h264nf_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  item_t              item,
  input  logic [LIMIT_W-1:0] limit,
  output bundle_t            bundle
);

  logic [SIZE_BITS-1:0] byte_pos_r, byte_pos_nxt;
  logic [SIZE_BITS-1:0] bytes_rem_r, bytes_rem_nxt;
  logic [7:0]           held_hdr_r, held_hdr_nxt;
  logic [LIMIT_W-1:0]   frag_fill_r, frag_fill_nxt;
  logic                 frag_mode_r, frag_mode_nxt;
  logic                 first_pend_r, first_pend_nxt;

  logic [SIZE_BITS-1:0] size_m;
  logic [SIZE_BITS-1:0] pos_inc;
  logic [LIMIT_W-1:0]   lim_eff;
  logic [LIMIT_W-1:0]   pmax;
  logic [LIMIT_W-1:0]   fill_inc;
  logic                 frag_fin;
  logic                 last_byte;
  logic [7:0]           fu_ind;
  logic [7:0]           fu_hdr;

  // Mask packet_size to the counter width.
  always_comb begin
    for (int i = 0; i < SIZE_BITS; i++) begin
      size_m[i] = (i < PKT_SIZE_W) ? item.packet_size[i] : 1'b0;
    end
  end

  assign lim_eff   = (limit < LIMIT_MIN) ? LIMIT_MIN : limit;
  assign pmax      = lim_eff - 16'd2;
  assign pos_inc   = byte_pos_r + SIZE_BITS'(1);
  assign last_byte = (bytes_rem_r == SIZE_BITS'(1));
  assign fill_inc  = frag_fill_r + 16'd1;
  assign frag_fin  = (fill_inc >= pmax) || last_byte;
  assign fu_ind    = (held_hdr_r & NRI_MASK) | FU_A_TYPE;
  assign fu_hdr    = (held_hdr_r & TYPE_MASK)
                   | (first_pend_r ? START_BIT : 8'h00)
                   | ((bytes_rem_r <= SIZE_BITS'(pmax)) ? END_BIT : 8'h00);

  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    bytes_rem_nxt  = bytes_rem_r;
    held_hdr_nxt   = held_hdr_r;
    frag_fill_nxt  = frag_fill_r;
    frag_mode_nxt  = frag_mode_r;
    first_pend_nxt = first_pend_r;
    bundle         = '0;

    priority if (item.first_of_packet) begin
      frag_fill_nxt  = '0;
      first_pend_nxt = 1'b1;
      held_hdr_nxt   = '0;
      if (size_m < SIZE_BITS'(MIN_PACKET)) begin
        bytes_rem_nxt = '0;
        byte_pos_nxt  = '0;
        frag_mode_nxt = 1'b0;
      end else begin
        byte_pos_nxt  = SIZE_BITS'(1);
        bytes_rem_nxt = size_m - SIZE_BITS'(1);
        frag_mode_nxt = (size_m - SIZE_BITS'(START_LEN)) > SIZE_BITS'(lim_eff);
      end
    end else if (bytes_rem_r != '0) begin
      byte_pos_nxt  = pos_inc;
      bytes_rem_nxt = bytes_rem_r - SIZE_BITS'(1);
      if (pos_inc > SIZE_BITS'(START_LEN)) begin
        priority if (!frag_mode_r) begin
          bundle.cnt    = 2'd1;
          bundle.res[0] = mk_res(item.in_byte, pos_inc == SIZE_BITS'(NAL_POS),
                                 last_byte, 1'b1);
        end else if (pos_inc == SIZE_BITS'(NAL_POS)) begin
          held_hdr_nxt = item.in_byte;
        end else begin
          frag_fill_nxt = frag_fin ? '0 : fill_inc;
          if (frag_fill_r == '0) begin
            // open a fragment: indicator and FU header go ahead of the payload
            first_pend_nxt = 1'b0;
            bundle.cnt     = 2'd3;
            bundle.res[0]  = mk_res(fu_ind, 1'b1, 1'b0, 1'b0);
            bundle.res[1]  = mk_res(fu_hdr, 1'b0, 1'b0, 1'b0);
            bundle.res[2]  = mk_res(item.in_byte, 1'b0, frag_fin, 1'b1);
          end else begin
            bundle.cnt    = 2'd1;
            bundle.res[0] = mk_res(item.in_byte, 1'b0, frag_fin, 1'b1);
          end
        end
      end
    end else begin
      // idle: drop the byte, hold the state
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r   <= '0;
      bytes_rem_r  <= '0;
      held_hdr_r   <= '0;
      frag_fill_r  <= '0;
      frag_mode_r  <= 1'b0;
      first_pend_r <= 1'b0;
    end else if (adv) begin
      byte_pos_r   <= byte_pos_nxt;
      bytes_rem_r  <= bytes_rem_nxt;
      held_hdr_r   <= held_hdr_nxt;
      frag_fill_r  <= frag_fill_nxt;
      frag_mode_r  <= frag_mode_nxt;
      first_pend_r <= first_pend_nxt;
    end
  end

endmodule

// ===== design/h264nf_outq.sv =====
// ----------------------------------------------------------------------------
// h264nf_outq
// Four-slot result queue: loads a bundle of up to three results, drains one.
// ----------------------------------------------------------------------------
module h264nf_outq import h264nf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  bundle_t bundle,
  input  logic    pop_rdy,
  output logic    head_vld,
  output result_t head,
  output logic    room
);

  result_t [OUTQ_DEPTH-1:0] slots_r, slots_nxt, shifted;
  logic [OUTQ_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [OUTQ_CNT_W-1:0]    base;
  logic [OUTQ_CNT_W-1:0]    top;
  logic [OUTQ_CNT_W-1:0]    rel;
  logic                     pop;

  assign head_vld = (cnt_r != '0);
  assign head     = slots_r[0];
  assign pop      = head_vld && pop_rdy;
  // a full bundle fits when at most one result is left
  assign room     = (cnt_r <= OUTQ_CNT_W'(OUTQ_DEPTH - MAX_RESULTS));
  assign base     = cnt_r - OUTQ_CNT_W'(pop);
  assign top      = base + OUTQ_CNT_W'(bundle.cnt);
  assign cnt_nxt  = load ? top : base;

  always_comb begin
    for (int i = 0; i < OUTQ_DEPTH - 1; i++) begin
      shifted[i] = pop ? slots_r[i+1] : slots_r[i];
    end
    shifted[OUTQ_DEPTH-1] = slots_r[OUTQ_DEPTH-1];
  end

  always_comb begin
    rel = '0;
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      rel          = OUTQ_CNT_W'(i) - base;
      slots_nxt[i] = shifted[i];
      if (load && (OUTQ_CNT_W'(i) >= base) && (OUTQ_CNT_W'(i) < top)) begin
        slots_nxt[i] = bundle.res[rel[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    slots_r <= slots_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== design/h264_nal_fragmenter.sv =====
// ----------------------------------------------------------------------------
// h264_nal_fragmenter
// Strips start codes from H.264 packets and passes or FU-A fragments the NAL.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+-----------------------------------------
//  in_ch    | in  | valid / ready     | in_byte, first_of_packet, packet_size
//  out_ch   | out | valid / ready     | out_byte, packet_begin, packet_finish,
//           |     |                   | run_last
//  cfg_*    | in  | cfg_wr_en (write) | cfg_wr_data = max_packet_bytes
//
//  An accepted byte lands in the input register and is stepped from there when
//  its results fit: a byte that yields results needs the output queue to hold
//  at most one. Sustained rate is one byte per cycle while the queue has room;
//  a fragment start yields three results, so the queue drain (one transaction
//  per cycle) holds the input there until the queue has room again.
//  rst_n is synchronous: it clears the packet state, the queue and the register.
//  An output stall holds the queue; the input keeps flowing until it fills.
// ----------------------------------------------------------------------------
module h264_nal_fragmenter import h264nf_pkg::*; #(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  h264nf_in_if.sink          in_ch,
  h264nf_out_if.source       out_ch,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  // Packet limit register.
  logic [LIMIT_W-1:0] max_pkt_r;

  // Input register.
  logic    in_vld_r, in_vld_nxt;
  item_t   in_item_r;
  logic    in_take;

  // Step and queue.
  bundle_t bundle;
  logic    fire;
  logic    q_room;
  result_t q_head;
  logic    q_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pkt_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_pkt_r <= cfg_wr_data;
    end
  end

  // Step the held byte when its results fit; bytes with no result always go.
  assign fire        = in_vld_r && ((bundle.cnt == 2'd0) || q_room);
  assign in_ch.ready = !in_vld_r || fire;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (fire) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.in_byte         <= in_ch.in_byte;
      in_item_r.first_of_packet <= in_ch.first_of_packet;
      in_item_r.packet_size     <= in_ch.packet_size;
    end
  end

  h264nf_step #(
    .SIZE_BITS (SIZE_BITS)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (fire),
    .item   (in_item_r),
    .limit  (max_pkt_r),
    .bundle (bundle)
  );

  h264nf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (fire),
    .bundle   (bundle),
    .pop_rdy  (out_ch.ready),
    .head_vld (q_vld),
    .head     (q_head),
    .room     (q_room)
  );

  assign out_ch.valid         = q_vld;
  assign out_ch.out_byte      = q_head.out_byte;
  assign out_ch.packet_begin  = q_head.packet_begin;
  assign out_ch.packet_finish = q_head.packet_finish;
  assign out_ch.run_last      = q_head.run_last;

`ifndef SYNTHESIS
  // A held byte that is not stepped must stay untouched.
  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !fire |=> in_vld_r && $stable(in_item_r))
    else $error("input register changed while its byte was waiting");

  // An empty queue always has room for a full bundle.
  a_empty_room: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> q_room)
    else $error("output queue reports no room while empty");

  // Results only enter the queue when it can take all of them; checks that stepped results reach the queue.
  a_load_fits: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (bundle.cnt != 2'd0) |=> out_ch.valid)
    else $error("stepped results did not reach the output queue");
`endif

endmodule
